// ===== sv/wmib_pkg.sv =====
package wmib_pkg;

    // Sizing of the blend
    localparam int MAX_IMAGES  = 16;
    localparam int WEIGHT_BITS = 16;

    // Field widths of one beat
    localparam int WEIGHT_W = 16;
    localparam int SAMPLE_W = 8;
    localparam int NUM_CH   = 3;

    // Weight bits that take part in the sums
    localparam int WEIGHT_USE = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
    localparam int WT_W       = WEIGHT_USE + $clog2(MAX_IMAGES);
    localparam int CH_W       = WT_W + SAMPLE_W;
    localparam int STEP_W     = $clog2(SAMPLE_W);

    localparam int IN_DATA_W  = WEIGHT_W + NUM_CH * SAMPLE_W;
    localparam int OUT_DATA_W = NUM_CH * SAMPLE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_image;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/wmib_ctrl.sv =====
module wmib_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wmib_pkg::dp_status_t  status,
    output wmib_pkg::ctrl_cmd_t   cmd
);

    wmib_pkg::state_t state_reg;
    wmib_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmib_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmib_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wmib_pkg::ST_ACC;
                end
            end
            wmib_pkg::ST_ACC:
            begin
                state_next = status.last_image ? wmib_pkg::ST_PREP : wmib_pkg::ST_IDLE;
            end
            wmib_pkg::ST_PREP:
            begin
                state_next = wmib_pkg::ST_DIV;
            end
            wmib_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = wmib_pkg::ST_EMIT;
                end
            end
            wmib_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = wmib_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wmib_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            wmib_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            wmib_pkg::ST_ACC:
            begin
                cmd.accumulate = 1'b1;
            end
            wmib_pkg::ST_PREP:
            begin
                cmd.div_start = 1'b1;
            end
            wmib_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            wmib_pkg::ST_EMIT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/wmib_dp.sv =====
module wmib_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wmib_pkg::ctrl_cmd_t                  cmd,
    output wmib_pkg::dp_status_t                 status,
    input  logic                                 cfg_we,
    input  logic                                 cfg_color,
    input  logic [wmib_pkg::WEIGHT_W-1:0]        weight,
    input  logic [wmib_pkg::SAMPLE_W-1:0]        blue,
    input  logic [wmib_pkg::SAMPLE_W-1:0]        green,
    input  logic [wmib_pkg::SAMPLE_W-1:0]        red,
    input  logic                                 last_image,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [wmib_pkg::SAMPLE_W-1:0]        out_blue,
    output logic [wmib_pkg::SAMPLE_W-1:0]        out_green,
    output logic [wmib_pkg::SAMPLE_W-1:0]        out_red,
    output logic                                 uncovered
);

    // Captured input beat
    logic [wmib_pkg::WEIGHT_USE-1:0] weight_reg;
    logic [wmib_pkg::SAMPLE_W-1:0]   sample_reg [wmib_pkg::NUM_CH];
    logic                            last_reg;

    // Pixel totals
    logic [wmib_pkg::WT_W-1:0]       wt_total_reg;
    logic [wmib_pkg::CH_W-1:0]       ch_total_reg [wmib_pkg::NUM_CH];
    logic [wmib_pkg::CNT_W-1:0]      seen_reg;
    logic                            color_reg;

    // Divider
    logic [wmib_pkg::WT_W-1:0]       den_reg;
    logic [wmib_pkg::CH_W-1:0]       rem_reg [wmib_pkg::NUM_CH];
    logic [wmib_pkg::SAMPLE_W-1:0]   quo_reg [wmib_pkg::NUM_CH];
    logic [wmib_pkg::STEP_W-1:0]     step_reg;

    // Output register
    logic                            out_valid_reg;
    logic [wmib_pkg::SAMPLE_W-1:0]   out_ch_reg [wmib_pkg::NUM_CH];
    logic                            uncov_reg;

    logic                            room;
    logic                            out_free;
    logic [wmib_pkg::CH_W-1:0]       trial;
    logic [wmib_pkg::CH_W-1:0]       prod [wmib_pkg::NUM_CH];
    logic                            fits [wmib_pkg::NUM_CH];
    logic [wmib_pkg::CH_W-1:0]       diff [wmib_pkg::NUM_CH];
    logic                            zero_wt;

    assign room     = seen_reg < wmib_pkg::CNT_W'(wmib_pkg::MAX_IMAGES);
    assign out_free = !out_valid_reg || out_ready;
    assign trial    = wmib_pkg::CH_W'(den_reg) << step_reg;
    assign zero_wt  = (den_reg == '0);

    always_comb
    begin
        for (int c = 0; c < wmib_pkg::NUM_CH; c++)
        begin
            prod[c] = wmib_pkg::CH_W'(weight_reg) * wmib_pkg::CH_W'(sample_reg[c]);
            fits[c] = rem_reg[c] >= trial;
            diff[c] = rem_reg[c] - trial;
        end
    end

    assign status.last_image = last_reg;
    assign status.div_last   = (step_reg == '0);
    assign status.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            weight_reg    <= weight[wmib_pkg::WEIGHT_USE-1:0];
            sample_reg[0] <= blue;
            sample_reg[1] <= green;
            sample_reg[2] <= red;
            last_reg      <= last_image;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            color_reg <= cfg_color;
        end
    end

    // Accumulate, then hand the totals to the divider and clear them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_total_reg <= '0;
            seen_reg     <= '0;
            for (int c = 0; c < wmib_pkg::NUM_CH; c++)
            begin
                ch_total_reg[c] <= '0;
            end
        end
        else if (cmd.div_start)
        begin
            wt_total_reg <= '0;
            seen_reg     <= '0;
            for (int c = 0; c < wmib_pkg::NUM_CH; c++)
            begin
                ch_total_reg[c] <= '0;
            end
        end
        else if (cmd.accumulate && room)
        begin
            wt_total_reg <= wt_total_reg + wmib_pkg::WT_W'(weight_reg);
            seen_reg     <= seen_reg + 1'b1;
            for (int c = 0; c < wmib_pkg::NUM_CH; c++)
            begin
                ch_total_reg[c] <= ch_total_reg[c] + prod[c];
            end
        end
    end

    // Restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            step_reg <= wmib_pkg::STEP_W'(wmib_pkg::SAMPLE_W - 1);
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den_reg <= wt_total_reg;
            for (int c = 0; c < wmib_pkg::NUM_CH; c++)
            begin
                rem_reg[c] <= ch_total_reg[c];
                quo_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < wmib_pkg::NUM_CH; c++)
            begin
                if (fits[c])
                begin
                    rem_reg[c]           <= diff[c];
                    quo_reg[c][step_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            uncov_reg     <= zero_wt;
            out_ch_reg[0] <= zero_wt ? '0 : quo_reg[0];
            out_ch_reg[1] <= (zero_wt || !color_reg) ? '0 : quo_reg[1];
            out_ch_reg[2] <= (zero_wt || !color_reg) ? '0 : quo_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = out_ch_reg[0];
    assign out_green = out_ch_reg[1];
    assign out_red   = out_ch_reg[2];
    assign uncovered = uncov_reg;

endmodule

// ===== sv/weighted_multi_image_blend_top.sv =====
// Weighted multi-image blend: one output pixel from a run of source images.
// Input stream (s_*): one beat per source image at the pixel, carrying its
// mask weight and blue, green, red samples; s_tlast marks the last image.
// Output stream (m_*): one beat per pixel, the weighted average per channel
// (truncated) and tuser = uncovered when all weights were zero (black out).
// Config channel (cfg_*): writes color_mode (1 = blue/green/red, 0 = gray in
// blue, green and red read zero); always ready, write it only while idle.
// Each beat is captured, then multiply-accumulated, before the next is taken.
// After the last beat the sums are loaded into the restoring divider, which
// makes one quotient bit per cycle for all three channels together; the
// quotients then go to the output register, which raises m_tvalid.
// Images past MAX_IMAGES in one pixel are dropped from the sums.
// Reset clears the sums and the output valid flag and sets color mode.
// A stalled receiver holds the result in the output register; the block
// keeps accepting the next pixel's beats and only waits at the end of that
// pixel until the held result has been taken.
module weighted_multi_image_blend_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: weight[15:0], blue[23:16], green[31:24], red[39:32]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wmib_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // m_tdata: out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wmib_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: uncovered
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);

    wmib_pkg::ctrl_cmd_t  cmd;
    wmib_pkg::dp_status_t status;

    logic [wmib_pkg::SAMPLE_W-1:0] out_blue;
    logic [wmib_pkg::SAMPLE_W-1:0] out_green;
    logic [wmib_pkg::SAMPLE_W-1:0] out_red;

    assign cfg_ready = 1'b1;

    wmib_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Unpack the input beat: weight lowest, then blue, green, red
    wmib_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid),
        .cfg_color  (cfg_data),
        .weight     (s_tdata[wmib_pkg::WEIGHT_W-1:0]),
        .blue       (s_tdata[wmib_pkg::WEIGHT_W +: wmib_pkg::SAMPLE_W]),
        .green      (s_tdata[wmib_pkg::WEIGHT_W + wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W]),
        .red        (s_tdata[wmib_pkg::WEIGHT_W + 2*wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W]),
        .last_image (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .uncovered  (m_tuser)
    );

    assign m_tdata = {out_red, out_green, out_blue};

endmodule

// ===== sim/weighted_multi_image_blend_top_tb.sv =====
`timescale 1ns / 100ps

module weighted_multi_image_blend_top_tb;

    // Cycles to let pass after the last result before touching the config
    // channel or ending the run.
    localparam int DRAIN_CYCLES = 16;

    // One blended pixel as it leaves the block
    typedef struct packed {
        logic [wmib_pkg::SAMPLE_W-1:0] red;
        logic [wmib_pkg::SAMPLE_W-1:0] green;
        logic [wmib_pkg::SAMPLE_W-1:0] blue;
        logic                          uncovered;
    } pixel_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [wmib_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic                              s_tlast = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [wmib_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_data = 1'b0;

    // Shadow of the blend state, kept in step with accepted beats
    logic                              color_shadow = 1'b1;
    logic [wmib_pkg::WT_W-1:0]         weight_sum = '0;
    logic [wmib_pkg::CH_W-1:0]         blue_sum = '0;
    logic [wmib_pkg::CH_W-1:0]         green_sum = '0;
    logic [wmib_pkg::CH_W-1:0]         red_sum = '0;
    logic [wmib_pkg::CNT_W-1:0]        image_count = '0;
    pixel_t                            expected_pixels[$];

    // Knobs for the two sides
    bit                                tx_idle_on = 1'b1;
    bit                                rx_idle_on = 1'b1;
    int                                long_hold_cycles = 0;

    // Bookkeeping
    int                                error_count = 0;
    int                                beats_sent = 0;
    int                                pixels_checked = 0;
    int                                uncovered_pixels = 0;
    int                                gray_pixels = 0;
    int                                dropped_beats = 0;

    weighted_multi_image_blend_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("timeout: %0d pixels still expected", expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Fold one accepted beat into the running sums; on the last image of
    // the pixel, divide the sums by the weight sum and queue the expected output beat.
    task automatic blend_accumulate(input logic [wmib_pkg::IN_DATA_W-1:0] data,
                                    input logic last);
        logic [wmib_pkg::WEIGHT_W-1:0] w;
        logic [wmib_pkg::SAMPLE_W-1:0] b;
        logic [wmib_pkg::SAMPLE_W-1:0] g;
        logic [wmib_pkg::SAMPLE_W-1:0] r;
        logic [wmib_pkg::CH_W-1:0]     quot;
        pixel_t                        px;
        w = data[wmib_pkg::WEIGHT_W-1:0]
            & wmib_pkg::WEIGHT_W'((64'd1 << wmib_pkg::WEIGHT_USE) - 1);
        b = data[wmib_pkg::WEIGHT_W +: wmib_pkg::SAMPLE_W];
        g = data[wmib_pkg::WEIGHT_W + wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W];
        r = data[wmib_pkg::WEIGHT_W + 2 * wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W];
        // Drop images past the per-pixel limit; they still may end the pixel
        if (image_count < wmib_pkg::MAX_IMAGES)
        begin
            weight_sum  = weight_sum + wmib_pkg::WT_W'(w);
            blue_sum    = blue_sum + wmib_pkg::CH_W'(w) * wmib_pkg::CH_W'(b);
            green_sum   = green_sum + wmib_pkg::CH_W'(w) * wmib_pkg::CH_W'(g);
            red_sum     = red_sum + wmib_pkg::CH_W'(w) * wmib_pkg::CH_W'(r);
            image_count = image_count + 1'b1;
        end
        else
            dropped_beats++;
        if (last)
        begin
            px = '0;
            if (weight_sum == '0)
            begin
                // No coverage at all: black with the uncovered flag
                px.uncovered = 1'b1;
                uncovered_pixels++;
            end
            else
            begin
                quot = blue_sum / wmib_pkg::CH_W'(weight_sum);
                px.blue = quot[wmib_pkg::SAMPLE_W-1:0];
                if (color_shadow)
                begin
                    quot = green_sum / wmib_pkg::CH_W'(weight_sum);
                    px.green = quot[wmib_pkg::SAMPLE_W-1:0];
                    quot = red_sum / wmib_pkg::CH_W'(weight_sum);
                    px.red = quot[wmib_pkg::SAMPLE_W-1:0];
                end
            end
            if (!color_shadow)
                gray_pixels++;
            expected_pixels = {expected_pixels, px};
            weight_sum  = '0;
            blue_sum    = '0;
            green_sum   = '0;
            red_sum     = '0;
            image_count = '0;
        end
    endtask

    // Track config writes and input beats at the edge they are taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                color_shadow = cfg_data;
            if (s_tvalid && s_tready)
                blend_accumulate(s_tdata, s_tlast);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 30)
            $display("MISMATCH at %0t ns, pixel %0d: %s got %0d expected %0d",
                     $time, pixels_checked, what, got, want);
        error_count++;
    endtask

    // Compare each output beat with the oldest expected pixel
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected output beat, count", 1, 0);
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata[wmib_pkg::SAMPLE_W-1:0] !== want.blue)
                    report_mismatch("out_blue", int'(m_tdata[wmib_pkg::SAMPLE_W-1:0]),
                                    int'(want.blue));
                if (m_tdata[wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W] !== want.green)
                    report_mismatch("out_green",
                                    int'(m_tdata[wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W]),
                                    int'(want.green));
                if (m_tdata[2 * wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W] !== want.red)
                    report_mismatch("out_red",
                                    int'(m_tdata[2 * wmib_pkg::SAMPLE_W +: wmib_pkg::SAMPLE_W]),
                                    int'(want.red));
                if (m_tuser !== want.uncovered)
                    report_mismatch("uncovered", int'(m_tuser), int'(want.uncovered));
            end
            pixels_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int gap;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                long_hold_cycles--;
            end
            else if (gap > 0)
            begin
                m_tready <= 1'b0;
                gap--;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                // Stall burst of random length, this one included
                m_tready <= 1'b0;
                gap = $urandom_range(0, 14);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat, idling first at random; return at the accepting edge
    // with tvalid still high so a following beat can go out back to back.
    task automatic send_beat(input logic [wmib_pkg::WEIGHT_W-1:0] w,
                             input logic [wmib_pkg::SAMPLE_W-1:0] b,
                             input logic [wmib_pkg::SAMPLE_W-1:0] g,
                             input logic [wmib_pkg::SAMPLE_W-1:0] r,
                             input logic last);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tdata  <= {r, g, b, w};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // Stop offering and hold until every expected pixel has come out; the wait
    // starts after the next edge so the beat just taken is already in the expected queue
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write color_mode; the block must be idle, so drain first
    task automatic write_color_mode(input logic mode);
        wait_results_drained();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One pixel of random length and content. Lengths are mostly short,
    // sometimes past the image limit; some pixels carry no weight at all.
    task automatic send_random_pixel();
        int                            n;
        int                            pick;
        bit                            no_cover;
        logic [wmib_pkg::WEIGHT_W-1:0] w;
        logic [wmib_pkg::SAMPLE_W-1:0] smp[3];
        pick = $urandom_range(0, 19);
        if (pick == 0)
            n = $urandom_range(wmib_pkg::MAX_IMAGES, wmib_pkg::MAX_IMAGES + 4);
        else if (pick < 5)
            n = $urandom_range(7, wmib_pkg::MAX_IMAGES);
        else
            n = $urandom_range(1, 6);
        no_cover = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       w = '0;
                1:       w = '1;
                2:       w = wmib_pkg::WEIGHT_W'($urandom_range(1, 3));
                default: w = wmib_pkg::WEIGHT_W'($urandom);
            endcase
            if (no_cover)
                w = '0;
            for (int c = 0; c < 3; c++)
            begin
                case ($urandom_range(0, 9))
                    0:       smp[c] = '0;
                    1:       smp[c] = '1;
                    default: smp[c] = wmib_pkg::SAMPLE_W'($urandom);
                endcase
            end
            send_beat(w, smp[0], smp[1], smp[2], i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Color mode out of reset: field extremes, zero coverage, mixed weights
    // and a pixel that runs past the image limit.
    task automatic test_directed_color();
        send_beat(16'hFFFF, 8'hFF, 8'h00, 8'hAA, 1'b1);
        send_beat(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_beat(16'h0000, 8'h12, 8'h34, 8'h56, 1'b0);
        send_beat(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_beat(16'h0001, 8'h00, 8'hFF, 8'h80, 1'b0);
        send_beat(16'hFFFF, 8'hFF, 8'h00, 8'h7F, 1'b1);
        send_beat(16'h8000, 8'h01, 8'h02, 8'h03, 1'b0);
        send_beat(16'h8000, 8'h02, 8'h03, 8'h04, 1'b1);
        send_beat(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_beat(16'h0003, 8'h10, 8'h20, 8'h30, 1'b1);
        // Seventeen images: the last one is dropped from the sums
        for (int i = 0; i < wmib_pkg::MAX_IMAGES; i++)
            send_beat(wmib_pkg::WEIGHT_W'(i + 1), wmib_pkg::SAMPLE_W'(i),
                      wmib_pkg::SAMPLE_W'(3 * i), wmib_pkg::SAMPLE_W'(15 * i), 1'b0);
        send_beat(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    // Gray mode: green and red read zero whatever the samples
    task automatic test_gray_mode();
        write_color_mode(1'b0);
        send_beat(16'hFFFF, 8'h00, 8'hFF, 8'hFF, 1'b1);
        send_beat(16'h1234, 8'hC8, 8'h55, 8'hAA, 1'b0);
        send_beat(16'h4321, 8'h37, 8'hAA, 8'h55, 1'b1);
        send_beat(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        write_color_mode(1'b1);
    endtask

    // Hold the output off for a long stretch while pixels keep coming, so
    // the block holds one result and then stalls its input.
    task automatic test_output_backpressure();
        long_hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_random_pixel();
        wait_results_drained();
    endtask

    // Pause the sender until every result is out, then carry on
    task automatic test_sender_pause();
        for (int i = 0; i < 5; i++)
            send_random_pixel();
        wait_results_drained();
        for (int i = 0; i < 5; i++)
            send_random_pixel();
    endtask

    // Bulk random pixels over alternating modes, idling switched on and off
    task automatic test_random_phases();
        int start;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_color_mode(phase[0] ? 1'b1 : 1'b0);
            start = beats_sent;
            while (beats_sent - start < 450)
            begin
                // Stretches with no idling on either side now and then
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                send_random_pixel();
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Full rate on both sides to close the run
    task automatic test_full_rate();
        int start;
        write_color_mode(1'b1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        start = beats_sent;
        while (beats_sent - start < 200)
            send_random_pixel();
        wait_results_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_color();
        test_gray_mode();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases();
        test_full_rate();

        if (expected_pixels.size() != 0)
            report_mismatch("pixels never produced", 0, expected_pixels.size());

        $display("Blended %0d pixels from %0d source beats: %0d uncovered, %0d gray,",
                 pixels_checked, beats_sent, uncovered_pixels, gray_pixels);
        $display("%0d beats past the image limit, with output hold-off and sender pauses.",
                 dropped_beats);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
